[rtl/assert_macros.svh]
// Assertion macros for the checker module of the grid split block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PGS_ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define PGS_ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pgs_pkg.sv]
// Shared types and constants of the processor grid split block.
// Depends on nothing; used by the interfaces, the controller and the datapath.
package pgs_pkg;

   // Width of every count field on the request and response channels.
   localparam int FIELD_BITS = 16;

   // Defaults for the top-level parameters.
   localparam int MAX_FACTORS_DEFAULT = 16;
   localparam int COUNT_BITS_DEFAULT = 16;

   // Axis index and its codes.
   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIV_N,
      ST_PLACE,
      ST_START_R,
      ST_DIV_R,
      ST_CHOOSE,
      ST_APPLY,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_start;
      logic div_sel_rem;
      logic trial_hit;
      logic trial_miss;
      logic tail;
      logic mark_fail;
      logic axis_clear;
      logic axis_next;
      logic store_rem;
      logic choose;
      logic apply;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sq_gt_n;
      logic n_gt_one;
      logic div_done;
      logic div_rem_zero;
      logic used_full;
      logic last_axis;
      logic rsp_free;
   } status_type;

endpackage

[rtl/pgs_req_if.sv]
// Request channel of the grid split block: valid/ready handshake and counts.
// Depends on pgs_pkg for the field width.
interface pgs_req_if;
   logic                             valid;
   logic                             ready;
   logic [pgs_pkg::FIELD_BITS-1:0]   proc_count;
   logic [pgs_pkg::FIELD_BITS-1:0]   cells_x;
   logic [pgs_pkg::FIELD_BITS-1:0]   cells_y;
   logic [pgs_pkg::FIELD_BITS-1:0]   cells_z;

   modport source (output valid, output proc_count, output cells_x, output cells_y,
                   output cells_z, input ready);
   modport sink (input valid, input proc_count, input cells_x, input cells_y,
                 input cells_z, output ready);
endinterface

[rtl/pgs_rsp_if.sv]
// Response channel of the grid split block: valid/ready handshake and splits.
// Depends on pgs_pkg for the field width.
interface pgs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pgs_pkg::FIELD_BITS-1:0]   split_x;
   logic [pgs_pkg::FIELD_BITS-1:0]   split_y;
   logic [pgs_pkg::FIELD_BITS-1:0]   split_z;
   logic                             split_failed;

   modport source (output valid, output split_x, output split_y, output split_z,
                   output split_failed, input ready);
   modport sink (input valid, input split_x, input split_y, input split_z,
                 input split_failed, output ready);
endinterface

[rtl/processor_grid_split.sv]
// Each trial divisor tried and each prime factor placed runs through the
// single shared one-bit-per-cycle divider, which sets how long a request takes.
// Throughput: one request at a time; the next request is taken once the
// result sits in the response register. Reset is synchronous and clears the
// controller and the response valid; the block then waits ready for a request.
module processor_grid_split #(
   parameter int MAX_FACTORS = pgs_pkg::MAX_FACTORS_DEFAULT,
   parameter int COUNT_BITS  = pgs_pkg::COUNT_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   pgs_req_if.sink    req_chan,
   pgs_rsp_if.source  rsp_chan
);

   pgs_pkg::cmd_type    cmd;
   pgs_pkg::status_type status;

   // Sequencer.
   pgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and storage.
   pgs_dpath #(
      .MAX_FACTORS (MAX_FACTORS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_proc_count   (req_chan.proc_count),
      .req_cells_x      (req_chan.cells_x),
      .req_cells_y      (req_chan.cells_y),
      .req_cells_z      (req_chan.cells_z),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_split_x      (rsp_chan.split_x),
      .rsp_split_y      (rsp_chan.split_y),
      .rsp_split_z      (rsp_chan.split_z),
      .rsp_split_failed (rsp_chan.split_failed)
   );

endmodule

[rtl/pgs_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; instantiated by the grid split datapath.
module pgs_div #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CW = $clog2(WIDTH);

   logic             busy_ff;
   logic             done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [WIDTH-1:0] part_ff;
   logic [WIDTH-1:0] part_in;
   logic [WIDTH-1:0] quo_ff;
   logic [WIDTH-1:0] quo_in;
   logic [WIDTH-1:0] dvs_ff;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   // One restoring step: shift in the next dividend bit and try the subtract.
   always_comb begin
      shifted = {part_ff, quo_ff[WIDTH-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (!diff[WIDTH]) begin
         part_in = diff[WIDTH-1:0];
         quo_in  = {quo_ff[WIDTH-2:0], 1'b1};
      end else begin
         part_in = shifted[WIDTH-1:0];
         quo_in  = {quo_ff[WIDTH-2:0], 1'b0};
      end
   end

   // Sequencing: busy for WIDTH steps, then a one-cycle done pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand and partial result registers.
   always_ff @(posedge clock) begin
      if (start) begin
         part_ff <= '0;
         quo_ff  <= dividend;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         part_ff <= part_in;
         quo_ff  <= quo_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = part_ff;

endmodule

[rtl/pgs_dpath.sv]
// Datapath of the grid split block: counts, trial divisor, splits, divider
// and the response register. Depends on pgs_pkg and pgs_div.
module pgs_dpath #(
   parameter int MAX_FACTORS = pgs_pkg::MAX_FACTORS_DEFAULT,
   parameter int COUNT_BITS  = pgs_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pgs_pkg::cmd_type               cmd,
   output pgs_pkg::status_type            status,
   input  logic [pgs_pkg::FIELD_BITS-1:0] req_proc_count,
   input  logic [pgs_pkg::FIELD_BITS-1:0] req_cells_x,
   input  logic [pgs_pkg::FIELD_BITS-1:0] req_cells_y,
   input  logic [pgs_pkg::FIELD_BITS-1:0] req_cells_z,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [pgs_pkg::FIELD_BITS-1:0] rsp_split_x,
   output logic [pgs_pkg::FIELD_BITS-1:0] rsp_split_y,
   output logic [pgs_pkg::FIELD_BITS-1:0] rsp_split_z,
   output logic                           rsp_split_failed
);

   localparam int FB = pgs_pkg::FIELD_BITS;
   localparam int DW = (COUNT_BITS < FB) ? COUNT_BITS : FB;
   localparam int SW = DW + 2;
   localparam int UW = $clog2(MAX_FACTORS + 1);

   logic [DW-1:0]     n_ff;
   logic [DW-1:0]     d_ff;
   logic [SW-1:0]     sq_ff;
   logic [DW-1:0]     fact_ff;
   logic [DW-1:0]     rem_ff [3];
   logic [DW-1:0]     split_ff [3];
   logic [DW-1:0]     q_ff [3];
   logic [2:0]        rz_ff;
   logic [UW-1:0]     used_ff;
   logic              failed_ff;
   pgs_pkg::axis_type ax_ff;
   pgs_pkg::axis_type axis_ff;
   pgs_pkg::axis_type axis_in;
   logic              take_ff;
   logic              take_in;
   logic              rsp_valid_ff;
   logic [FB-1:0]     out_x_ff;
   logic [FB-1:0]     out_y_ff;
   logic [FB-1:0]     out_z_ff;
   logic              out_failed_ff;

   logic [DW-1:0]     div_dividend;
   logic [DW-1:0]     div_divisor;
   logic              div_done;
   logic [DW-1:0]     div_quo;
   logic [DW-1:0]     div_rem;
   logic [DW-1:0]     big_01;
   logic [DW-1:0]     big;
   logic [2:0]        at_big;
   logic [2*DW-1:0]   prod;

   // Divider operands: the count by the trial divisor, or an axis by the factor.
   assign div_dividend = cmd.div_sel_rem ? rem_ff[ax_ff] : n_ff;
   assign div_divisor  = cmd.div_sel_rem ? fact_ff : d_ff;

   pgs_div #(
      .WIDTH (DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Axis choice: first axis at the largest count that divides, else first
   // axis that divides at all; with none, the factor is not taken.
   always_comb begin
      big_01 = (rem_ff[0] >= rem_ff[1]) ? rem_ff[0] : rem_ff[1];
      big    = (big_01 >= rem_ff[2]) ? big_01 : rem_ff[2];
      at_big[0] = (rem_ff[0] == big) && rz_ff[0];
      at_big[1] = (rem_ff[1] == big) && rz_ff[1];
      at_big[2] = (rem_ff[2] == big) && rz_ff[2];
      take_in = 1'b1;
      priority if (at_big[0]) begin
         axis_in = pgs_pkg::AXIS_X;
      end else if (at_big[1]) begin
         axis_in = pgs_pkg::AXIS_Y;
      end else if (at_big[2]) begin
         axis_in = pgs_pkg::AXIS_Z;
      end else if (rz_ff[0]) begin
         axis_in = pgs_pkg::AXIS_X;
      end else if (rz_ff[1]) begin
         axis_in = pgs_pkg::AXIS_Y;
      end else if (rz_ff[2]) begin
         axis_in = pgs_pkg::AXIS_Z;
      end else begin
         axis_in = pgs_pkg::AXIS_X;
         take_in = 1'b0;
      end
   end

   // Split update product; it never exceeds the processor count.
   assign prod = (2 * DW)'(split_ff[axis_ff]) * (2 * DW)'(fact_ff);

   // Working registers of one request.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff        <= req_proc_count[DW-1:0];
         d_ff        <= DW'(2);
         sq_ff       <= SW'(4);
         rem_ff[0]   <= req_cells_x[DW-1:0];
         rem_ff[1]   <= req_cells_y[DW-1:0];
         rem_ff[2]   <= req_cells_z[DW-1:0];
         split_ff[0] <= DW'(1);
         split_ff[1] <= DW'(1);
         split_ff[2] <= DW'(1);
         used_ff     <= '0;
         failed_ff   <= 1'b0;
      end
      if (cmd.trial_hit) begin
         fact_ff <= d_ff;
         n_ff    <= div_quo;
      end
      if (cmd.trial_miss) begin
         // (d+1)^2 = d^2 + 2d + 1
         d_ff  <= d_ff + DW'(1);
         sq_ff <= sq_ff + SW'({d_ff, 1'b1});
      end
      if (cmd.tail) begin
         fact_ff <= n_ff;
         n_ff    <= DW'(1);
      end
      if (cmd.mark_fail) begin
         failed_ff <= 1'b1;
      end
      if (cmd.axis_clear) begin
         ax_ff <= pgs_pkg::AXIS_X;
      end
      if (cmd.axis_next) begin
         ax_ff <= ax_ff + 2'd1;
      end
      if (cmd.store_rem) begin
         rz_ff[ax_ff] <= (div_rem == '0);
         q_ff[ax_ff]  <= div_quo;
      end
      if (cmd.choose) begin
         axis_ff <= axis_in;
         take_ff <= take_in;
      end
      if (cmd.apply) begin
         used_ff <= used_ff + UW'(1);
         if (take_ff) begin
            split_ff[axis_ff] <= prod[DW-1:0];
            rem_ff[axis_ff]   <= q_ff[axis_ff];
         end else begin
            failed_ff <= 1'b1;
         end
      end
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_x_ff      <= FB'(split_ff[0]);
         out_y_ff      <= FB'(split_ff[1]);
         out_z_ff      <= FB'(split_ff[2]);
         out_failed_ff <= failed_ff;
      end
   end

   // Status toward the controller.
   always_comb begin
      status.sq_gt_n      = sq_ff > SW'(n_ff);
      status.n_gt_one     = n_ff > DW'(1);
      status.div_done     = div_done;
      status.div_rem_zero = (div_rem == '0);
      status.used_full    = (used_ff == UW'(MAX_FACTORS));
      status.last_axis    = (ax_ff == pgs_pkg::AXIS_Z);
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_split_x      = out_x_ff;
   assign rsp_split_y      = out_y_ff;
   assign rsp_split_z      = out_z_ff;
   assign rsp_split_failed = out_failed_ff;

endmodule

[rtl/pgs_ctrl.sv]
// Controller of the grid split block: sequences trial division and factor
// placement. Depends on pgs_pkg for the state, command and status types.
module pgs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pgs_pkg::status_type status,
   output pgs_pkg::cmd_type    cmd
);

   pgs_pkg::state_type state_ff;
   pgs_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pgs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pgs_pkg::ST_IDLE: begin
            if (req_valid) state_in = pgs_pkg::ST_TEST;
         end
         pgs_pkg::ST_TEST: begin
            if (status.sq_gt_n) begin
               state_in = status.n_gt_one ? pgs_pkg::ST_PLACE : pgs_pkg::ST_FINISH;
            end else begin
               state_in = pgs_pkg::ST_DIV_N;
            end
         end
         pgs_pkg::ST_DIV_N: begin
            if (status.div_done) begin
               state_in = status.div_rem_zero ? pgs_pkg::ST_PLACE : pgs_pkg::ST_TEST;
            end
         end
         pgs_pkg::ST_PLACE: begin
            state_in = status.used_full ? pgs_pkg::ST_TEST : pgs_pkg::ST_START_R;
         end
         pgs_pkg::ST_START_R: begin
            state_in = pgs_pkg::ST_DIV_R;
         end
         pgs_pkg::ST_DIV_R: begin
            if (status.div_done) begin
               state_in = status.last_axis ? pgs_pkg::ST_CHOOSE : pgs_pkg::ST_START_R;
            end
         end
         pgs_pkg::ST_CHOOSE: begin
            state_in = pgs_pkg::ST_APPLY;
         end
         pgs_pkg::ST_APPLY: begin
            state_in = pgs_pkg::ST_TEST;
         end
         pgs_pkg::ST_FINISH: begin
            if (status.rsp_free) state_in = pgs_pkg::ST_IDLE;
         end
         default: begin
            state_in = pgs_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands for the datapath.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         pgs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         pgs_pkg::ST_TEST: begin
            if (status.sq_gt_n) begin
               cmd.tail = status.n_gt_one;
            end else begin
               cmd.div_start = 1'b1;
            end
         end
         pgs_pkg::ST_DIV_N: begin
            if (status.div_done) begin
               cmd.trial_hit  = status.div_rem_zero;
               cmd.trial_miss = !status.div_rem_zero;
            end
         end
         pgs_pkg::ST_PLACE: begin
            cmd.mark_fail  = status.used_full;
            cmd.axis_clear = !status.used_full;
         end
         pgs_pkg::ST_START_R: begin
            cmd.div_start   = 1'b1;
            cmd.div_sel_rem = 1'b1;
         end
         pgs_pkg::ST_DIV_R: begin
            cmd.div_sel_rem = 1'b1;
            if (status.div_done) begin
               cmd.store_rem = 1'b1;
               cmd.axis_next = !status.last_axis;
            end
         end
         pgs_pkg::ST_CHOOSE: begin
            cmd.choose = 1'b1;
         end
         pgs_pkg::ST_APPLY: begin
            cmd.apply = 1'b1;
         end
         pgs_pkg::ST_FINISH: begin
            cmd.emit = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/pgs_assert.sv]
// Port-level assertions for the grid split block, bound to its top level.
// Depends on pgs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pgs_assert (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [pgs_pkg::FIELD_BITS-1:0] split_x,
   input logic [pgs_pkg::FIELD_BITS-1:0] split_y,
   input logic [pgs_pkg::FIELD_BITS-1:0] split_z,
   input logic                           split_failed
);

   // A stalled response keeps its contents.
   `PGS_ASSERT_CLK_RST(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(split_x) && $stable(split_y) && $stable(split_z) && $stable(split_failed)), "response changed while stalled")

   // Reset leaves no response pending.
   `PGS_ASSERT_CLK(a_rsp_reset, clock, reset |=> !rsp_valid, "response valid after reset")

   // A request is worked on alone: no second request right after one is taken.
   `PGS_ASSERT_CLK_RST(a_one_at_a_time, clock, reset, (req_valid && req_ready) |=> !req_ready, "request taken while busy")

   // Every split is a product of factors of the count and never zero.
   `PGS_ASSERT_CLK_RST(a_split_nonzero, clock, reset, rsp_valid |-> (split_x != '0 && split_y != '0 && split_z != '0), "zero split in response")

endmodule

bind processor_grid_split pgs_assert u_assert (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .split_x      (rsp_chan.split_x),
   .split_y      (rsp_chan.split_y),
   .split_z      (rsp_chan.split_z),
   .split_failed (rsp_chan.split_failed)
);

[tb/pgs_split_checker.sv]
// Scoreboard for the processor grid split block: watches both channels,
// predicts each split from the accepted request and compares the responses.
// Depends on pgs_pkg and the pgs_req_if / pgs_rsp_if channel interfaces.
module pgs_split_checker #(
   parameter int MAX_FACTORS = pgs_pkg::MAX_FACTORS_DEFAULT,
   parameter int COUNT_BITS  = pgs_pkg::COUNT_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   pgs_req_if   req_mon,
   pgs_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   checked_count,
   output int   flagged_count
);

   typedef logic [pgs_pkg::FIELD_BITS-1:0] count_type;

   typedef struct packed {
      count_type proc_count;
      count_type cells_x;
      count_type cells_y;
      count_type cells_z;
   } grid_req_type;

   typedef struct packed {
      count_type split_x;
      count_type split_y;
      count_type split_z;
      logic      split_failed;
   } grid_split_type;

   typedef struct packed {
      grid_req_type   req;
      grid_split_type split;
   } awaited_split_type;

   localparam longint unsigned COUNT_MASK = (64'd1 << COUNT_BITS) - 64'd1;

   // Splits awaited from the block, oldest request first.
   awaited_split_type awaited_splits[$];

   // Factor the processor count smallest prime first, then hand each prime to the
   // first axis at the largest count if that divides, else to the first divisible axis.
   function automatic grid_split_type predict_split(grid_req_type r);
      longint unsigned left;
      longint unsigned trial;
      longint unsigned peak;
      longint unsigned rem[3];
      longint unsigned part[3];
      longint unsigned primes[$];
      int              placed;
      int              axis;
      logic            failed;
      grid_split_type  s;
      left    = r.proc_count & COUNT_MASK;
      rem[0]  = r.cells_x & COUNT_MASK;
      rem[1]  = r.cells_y & COUNT_MASK;
      rem[2]  = r.cells_z & COUNT_MASK;
      part    = '{1, 1, 1};
      placed  = 0;
      failed  = 1'b0;
      if (left > 1) begin
         for (trial = 2; trial * trial <= left; trial++) begin
            while (left % trial == 0) begin
               primes.push_back(trial);
               left = left / trial;
            end
         end
         if (left > 1) primes.push_back(left);
      end
      foreach (primes[i]) begin
         if (placed >= MAX_FACTORS) begin
            // The factor budget is spent, so the rest go unassigned.
            failed = 1'b1;
         end else begin
            placed++;
            peak = rem[0];
            if (rem[1] > peak) peak = rem[1];
            if (rem[2] > peak) peak = rem[2];
            axis = -1;
            for (int a = 0; a < 3; a++) begin
               if (axis < 0 && rem[a] == peak && rem[a] % primes[i] == 0) axis = a;
            end
            for (int a = 0; a < 3; a++) begin
               if (axis < 0 && rem[a] % primes[i] == 0) axis = a;
            end
            if (axis < 0) begin
               failed = 1'b1;
            end else begin
               part[axis] = part[axis] * primes[i];
               rem[axis]  = rem[axis] / primes[i];
            end
         end
      end
      s.split_x      = count_type'(part[0]);
      s.split_y      = count_type'(part[1]);
      s.split_z      = count_type'(part[2]);
      s.split_failed = failed;
      return s;
   endfunction

   // Report one field that differs from its prediction; returns 1 on a mismatch.
   function automatic int report_field(string name, grid_req_type r, count_type want,
                                       count_type got);
      if (want === got) return 0;
      $display("%0t: %s expected %0d, got %0d (request count %0d cells %0d %0d %0d)",
               $time, name, want, got, r.proc_count, r.cells_x, r.cells_y, r.cells_z);
      return 1;
   endfunction

   // Compare each accepted response first, then record the request taken on
   // the same edge, since that request cannot have produced this response.
   always @(posedge clock) begin : scoreboard
      awaited_split_type head;
      grid_req_type      taken;
      int                errors;
      if (reset) begin
         awaited_splits.delete();
         fail_count    <= 0;
         pending_count <= 0;
         checked_count <= 0;
         flagged_count <= 0;
      end else begin
         errors = 0;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_splits.size() == 0) begin
               $display("%0t: response %0d %0d %0d flag %0b arrived with no request pending",
                        $time, rsp_mon.split_x, rsp_mon.split_y, rsp_mon.split_z,
                        rsp_mon.split_failed);
               errors++;
            end else begin
               head = awaited_splits.pop_front();
               errors += report_field("split_x", head.req, head.split.split_x, rsp_mon.split_x);
               errors += report_field("split_y", head.req, head.split.split_y, rsp_mon.split_y);
               errors += report_field("split_z", head.req, head.split.split_z, rsp_mon.split_z);
               errors += report_field("split_failed", head.req,
                                      count_type'(head.split.split_failed),
                                      count_type'(rsp_mon.split_failed));
               checked_count <= checked_count + 1;
               if (rsp_mon.split_failed === 1'b1) flagged_count <= flagged_count + 1;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            taken.proc_count = req_mon.proc_count;
            taken.cells_x    = req_mon.cells_x;
            taken.cells_y    = req_mon.cells_y;
            taken.cells_z    = req_mon.cells_z;
            head.req         = taken;
            head.split       = predict_split(taken);
            awaited_splits.push_back(head);
         end
         fail_count    <= fail_count + errors;
         pending_count <= awaited_splits.size();
      end
   end

endmodule

[tb/tb.sv]
// Top of the processor grid split testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on pgs_pkg, the channel
// interfaces, processor_grid_split and pgs_split_checker.
module tb;

   typedef logic [pgs_pkg::FIELD_BITS-1:0] count_type;

   // Receiver behavior, switched at random intervals.
   typedef enum int {
      RX_OPEN,
      RX_CHOPPY,
      RX_CHOKED
   } rx_mode_type;

   localparam int RANDOM_REQUESTS = 120;

   logic        clock;
   logic        reset;
   int          fail_count;
   int          pending_count;
   int          checked_count;
   int          flagged_count;
   int          burst_left;
   int          directed_sent;
   int          random_sent;
   rx_mode_type rx_mode;
   int          rx_hold;

   pgs_req_if req_bus ();
   pgs_rsp_if rsp_bus ();

   processor_grid_split dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   pgs_split_checker split_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .flagged_count (flagged_count)
   );

   // Free-running clock with a period of 10.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Overall time limit, far above the slowest legal run.
   initial begin
      #40000000;
      $display("processor_grid_split verification failed");
      $finish;
   end

   // Response back-pressure: open, choppy or mostly stalled for random spans.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_mode       <= RX_OPEN;
         rx_hold       <= 0;
      end else begin
         if (rx_hold == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 2));
            rx_hold <= $urandom_range(16, 200);
         end else begin
            rx_hold <= rx_hold - 1;
         end
         case (rx_mode)
            RX_OPEN: begin
               rsp_bus.ready <= 1'b1;
            end
            RX_CHOPPY: begin
               rsp_bus.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            end
         endcase
      end
   end

   // Product of a few small primes, kept within the field range.
   function automatic count_type smooth_number(int most_primes);
      int unsigned value;
      int unsigned prime;
      value = 1;
      repeat ($urandom_range(0, most_primes)) begin
         case ($urandom_range(0, 5))
            0: prime = 2;
            1: prime = 3;
            2: prime = 5;
            3: prime = 7;
            4: prime = 11;
            default: prime = 13;
         endcase
         if (value * prime <= 65535) value = value * prime;
      end
      return count_type'(value);
   endfunction

   // Cell count: smooth or fully random, now and then zero or all ones.
   function automatic count_type random_cells();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return smooth_number(8);
      if (pick < 90) return count_type'($urandom_range(1, 65535));
      if (pick < 95) return '0;
      return '1;
   endfunction

   // Present one request, with a random gap whenever a burst runs out, and
   // hold it until the block takes it.
   task automatic send_request(input count_type count, input count_type cx,
                               input count_type cy, input count_type cz);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(1, 6);
      end
      req_bus.valid      <= 1'b1;
      req_bus.proc_count <= count;
      req_bus.cells_x    <= cx;
      req_bus.cells_y    <= cy;
      req_bus.cells_z    <= cz;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
   endtask

   // Stop sending and wait until every outstanding request has been answered.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Stimulus: reset, a directed set of corner cases, then random requests.
   initial begin
      int unsigned pick;
      count_type   count;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.proc_count <= '0;
      req_bus.cells_x    <= '0;
      req_bus.cells_y    <= '0;
      req_bus.cells_z    <= '0;
      burst_left    = 0;
      directed_sent = 0;
      random_sent   = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Counts of one and zero have no prime factors.
      send_request(16'd1, 16'd8, 16'd8, 16'd8);
      send_request(16'd0, 16'd5, 16'd6, 16'd7);
      // All-ones fields, and the largest prime with and without an axis able to take it.
      send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(16'd65521, 16'd1, 16'd1, 16'd1);
      send_request(16'd65521, 16'd65521, 16'd3, 16'd0);
      send_request(16'hFFFF, 16'd1, 16'd1, 16'd1);
      // Zero cell counts are divisible by every factor.
      send_request(16'd32768, 16'd0, 16'd0, 16'd0);
      send_request(16'hFFFF, 16'd0, 16'd0, 16'd0);
      send_request(16'd12, 16'd0, 16'd16, 16'd9);
      // Longest chain of factors, and ties between axes.
      send_request(16'd32768, 16'd32768, 16'd1024, 16'd2);
      send_request(16'd64, 16'd64, 16'd64, 16'd64);
      // Largest axis not divisible, so a later axis takes the factor.
      send_request(16'd6, 16'd7, 16'd9, 16'd4);
      send_request(16'd7, 16'd4, 16'd4, 16'd4);
      send_request(16'd30030, 16'd30030, 16'd1, 16'd1);
      send_request(16'd1000, 16'd100, 16'd100, 16'd10);
      send_request(16'd49, 16'd7, 16'd49, 16'd14);
      send_request(16'd2, 16'd65535, 16'd65534, 16'd0);
      // Alternating bit patterns on every field.
      send_request(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      send_request(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_request(16'h8000, 16'h8000, 16'h4000, 16'h0001);
      directed_sent = 20;
      drain_responses();

      // Random requests, mostly with smooth counts so they finish quickly.
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == RANDOM_REQUESTS / 2) drain_responses();
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            count = smooth_number(10);
         end else if (pick < 95) begin
            count = count_type'($urandom_range(1, 65535));
         end else begin
            count = count_type'($urandom_range(0, 1));
         end
         send_request(count, random_cells(), random_cells(), random_cells());
         random_sent++;
      end

      // Let the last responses arrive, then watch for stray ones.
      drain_responses();
      repeat (100) @(posedge clock);

      $display("Sent %0d requests (%0d directed, %0d random) under varying back-pressure.",
               directed_sent + random_sent, directed_sent, random_sent);
      $display("Compared %0d responses, %0d of them with the failure flag set; %0d mismatches.",
               checked_count, flagged_count, fail_count);
      if (fail_count == 0) begin
         $display("processor_grid_split verification clean");
      end else begin
         $display("processor_grid_split verification failed");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/pgs_pkg.sv
rtl/pgs_req_if.sv
rtl/pgs_rsp_if.sv
rtl/pgs_div.sv
rtl/pgs_dpath.sv
rtl/pgs_ctrl.sv
rtl/processor_grid_split.sv
rtl/pgs_assert.sv
tb/pgs_split_checker.sv
tb/tb.sv
